/* hw/rtl/goca_pkg.sv */
// Shared types and constants for the goal ordering agenda block.
package goca_pkg;
    localparam int MAX_GOALS = 32;
    localparam int FACT_BITS = 16;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 6;
    localparam int DEG_W     = 7;

    typedef logic [MAX_GOALS-1:0] row_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic signed [DEG_W-1:0] deg_t;
    typedef logic [DEG_W-1:0]     hits_t;
    typedef logic [FACT_BITS-1:0] fact_t;

    typedef enum logic [5:0] {
        ST_LOAD    = 6'b000001,
        ST_CLOSE   = 6'b000010,
        ST_DEGREE  = 6'b000100,
        ST_SORT    = 6'b001000,
        ST_EMIT    = 6'b010000,
        ST_SHIFT   = 6'b100000
    } state_t;
endpackage

/* hw/rtl/goca_if.sv */
// Valid/ready channel interfaces for the goal ordering agenda block.
interface goca_in_if;
    import goca_pkg::*;
    logic  valid;
    logic  ready;
    slot_t goal_slot;
    logic [15:0] goal_fact;
    logic [31:0] order_row;
    logic  last_goal;
    modport source (output valid, goal_slot, goal_fact, order_row, last_goal, input ready);
    modport sink   (input valid, goal_slot, goal_fact, order_row, last_goal, output ready);
endinterface

interface goca_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  entry_index;
    logic [15:0] goal_fact_out;
    logic        last_in_entry;
    logic        last_overall;
    modport source (output valid, entry_index, goal_fact_out, last_in_entry, last_overall,
                    input ready);
    modport sink   (input valid, entry_index, goal_fact_out, last_in_entry, last_overall,
                    output ready);
endinterface

/* hw/rtl/goal_order_closure_agenda.sv */
// Goal ordering agenda: load, lane closure, degree count, sort and emit.
// Throughput: one goal row accepted per cycle while loading and no result is pending;
// one result per cycle on emit while the receiver is ready. After the last row: closure
// over each pivot, degree count over each row, then an insertion sort (a connected goal
// is placed by a scan and a shift, an unconnected goal i goes straight to slot i).
// Reset clears control state and goal count; row and fact stores keep no reset.
module goal_order_closure_agenda (
    input logic clk,
    input logic rst_n,
    goca_in_if.sink    in_ch,
    goca_out_if.source out_ch
);
    import goca_pkg::*;

    row_t   mat_reg  [MAX_GOALS];
    fact_t  fact_reg [MAX_GOALS];
    slot_t  sorted_reg [MAX_GOALS];
    state_t state_reg;
    cnt_t   n_reg;
    cnt_t   i_reg;
    cnt_t   p_reg;
    cnt_t   k_reg;
    row_t   keep;
    row_t   lane_row [MAX_GOALS];
    logic   lane_load;
    logic   lane_step;
    deg_t   deg  [MAX_GOALS];
    hits_t  hits [MAX_GOALS];
    row_t   diag_row;
    logic   ov_reg;
    logic [4:0] ent_reg;
    logic   lie_reg;
    logic   lov_reg;
    fact_t  fo_reg;
    cnt_t   e_reg;
    logic [4:0] entry_cnt_reg;
    slot_t  ins_idx;
    slot_t  sp;
    logic   brk;
    slot_t  sa;
    slot_t  sb;
    logic   starts_next;
    logic   starts_cur;
    slot_t  sc;

    assign keep = (n_reg >= cnt_t'(MAX_GOALS)) ? '1 : row_t'((64'd1 << n_reg) - 64'd1);
    assign lane_load = in_ch.valid && in_ch.ready && in_ch.last_goal;
    assign lane_step = (state_reg == ST_CLOSE);

    genvar g;
    generate
        for (g = 0; g < MAX_GOALS; g++)
        begin : g_lane
            goca_lane u_lane (
                .clk(clk), .load(lane_load),
                .load_row((slot_t'(g) == in_ch.goal_slot) ? in_ch.order_row : mat_reg[g]),
                .step(lane_step), .pivot(i_reg[SLOT_W-1:0]),
                .pivot_row(lane_row[i_reg[SLOT_W-1:0]]), .row(lane_row[g]));
        end
    endgenerate

    always_comb
    begin
        diag_row = lane_row[i_reg[SLOT_W-1:0]] & keep;
        diag_row[i_reg[SLOT_W-1:0]] = 1'b0;
    end

    goca_degree u_deg (
        .clk(clk), .clear(lane_load), .step(state_reg == ST_DEGREE),
        .idx(i_reg[SLOT_W-1:0]), .row(diag_row), .deg(deg), .hits(hits));

    assign ins_idx = i_reg[SLOT_W-1:0];
    assign sp  = sorted_reg[p_reg[SLOT_W-1:0]];
    assign brk = (deg[ins_idx] < deg[sp]) || (hits[sp] == '0);

    assign sc = sorted_reg[e_reg[SLOT_W-1:0]];
    assign sa = sorted_reg[e_reg[SLOT_W-1:0] - 1'b1];
    assign sb = sorted_reg[e_reg[SLOT_W-1:0] + 1'b1];
    assign starts_cur  = (e_reg != '0) &&
        ((deg[sc] != deg[sa]) || (hits[sc] == '0 && hits[sa] != '0));
    assign starts_next = (e_reg + 1'b1 == n_reg) ||
        (deg[sb] != deg[sc]) || (hits[sb] == '0 && hits[sc] != '0);

    assign in_ch.ready = (state_reg == ST_LOAD) && !ov_reg;

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            mat_reg[in_ch.goal_slot]  <= in_ch.order_row;
            fact_reg[in_ch.goal_slot] <= in_ch.goal_fact;
        end
        if (state_reg == ST_SORT && hits[ins_idx] == '0)
        begin
            sorted_reg[ins_idx] <= ins_idx;
        end
        if (state_reg == ST_SHIFT)
        begin
            if (k_reg > p_reg)
            begin
                sorted_reg[k_reg[SLOT_W-1:0]] <= sorted_reg[k_reg[SLOT_W-1:0] - 1'b1];
            end
            else
            begin
                sorted_reg[p_reg[SLOT_W-1:0]] <= ins_idx;
            end
        end
        if (state_reg == ST_EMIT && (!ov_reg || out_ch.ready))
        begin
            ent_reg <= entry_cnt_reg + 5'(starts_cur);
            fo_reg  <= fact_reg[sc];
            lie_reg <= starts_next;
            lov_reg <= (e_reg + 1'b1 == n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            n_reg <= '0;
            i_reg <= '0;
            p_reg <= '0;
            k_reg <= '0;
            e_reg <= '0;
            entry_cnt_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ch.ready && state_reg != ST_EMIT)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (lane_load)
                    begin
                        n_reg <= cnt_t'(in_ch.goal_slot) + 1'b1;
                        i_reg <= '0;
                        state_reg <= ST_CLOSE;
                    end
                end
                ST_CLOSE:
                begin
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        i_reg <= '0;
                        state_reg <= ST_DEGREE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_DEGREE:
                begin
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        i_reg <= '0;
                        p_reg <= '0;
                        state_reg <= ST_SORT;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_SORT:
                begin
                    if (hits[ins_idx] == '0 || p_reg == i_reg || brk)
                    begin
                        if (hits[ins_idx] == '0)
                        begin
                            p_reg <= '0;
                            if (i_reg + 1'b1 == n_reg)
                            begin
                                e_reg <= '0;
                                entry_cnt_reg <= '0;
                                state_reg <= ST_EMIT;
                            end
                            else
                            begin
                                i_reg <= i_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            k_reg <= i_reg;
                            state_reg <= ST_SHIFT;
                        end
                    end
                    else
                    begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
                ST_SHIFT:
                begin
                    if (k_reg > p_reg)
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                    else
                    begin
                        p_reg <= '0;
                        if (i_reg + 1'b1 == n_reg)
                        begin
                            e_reg <= '0;
                            entry_cnt_reg <= '0;
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            i_reg <= i_reg + 1'b1;
                            state_reg <= ST_SORT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!ov_reg || out_ch.ready)
                    begin
                        ov_reg <= 1'b1;
                        entry_cnt_reg <= entry_cnt_reg + 5'(starts_cur);
                        if (e_reg + 1'b1 == n_reg)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            e_reg <= e_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign out_ch.valid         = ov_reg;
    assign out_ch.entry_index   = ent_reg;
    assign out_ch.goal_fact_out = fo_reg;
    assign out_ch.last_in_entry = lie_reg;
    assign out_ch.last_overall  = lov_reg;
endmodule

/* hw/rtl/goca_lane.sv */
// One closure lane: loads its row, then on each step ORs pivot row into its own row when its pivot bit is set.
module goca_lane (
    input  logic            clk,
    input  logic            load,
    input  goca_pkg::row_t  load_row,
    input  logic            step,
    input  goca_pkg::slot_t pivot,
    input  goca_pkg::row_t  pivot_row,
    output goca_pkg::row_t  row
);
    import goca_pkg::*;
    row_t row_reg;
    row_t row_next;

    always_comb
    begin
        row_next = row_reg;
        if (load)
        begin
            row_next = load_row;
        end
        else if (step && row_reg[pivot])
        begin
            row_next = row_reg | pivot_row;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign row = row_reg;
endmodule

/* hw/rtl/goca_degree.sv */
// Degree merge: counts out-edges of one row and adds in-edges column-wise.
module goca_degree (
    input  logic            clk,
    input  logic            clear,
    input  logic            step,
    input  goca_pkg::slot_t idx,
    input  goca_pkg::row_t  row,
    output goca_pkg::deg_t  deg  [goca_pkg::MAX_GOALS],
    output goca_pkg::hits_t hits [goca_pkg::MAX_GOALS]
);
    import goca_pkg::*;
    deg_t  deg_reg  [MAX_GOALS];
    hits_t hits_reg [MAX_GOALS];
    hits_t out_cnt;

    always_comb
    begin
        out_cnt = '0;
        for (int k = 0; k < MAX_GOALS; k++)
        begin
            out_cnt = out_cnt + hits_t'(row[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_GOALS; k++)
        begin
            if (clear)
            begin
                deg_reg[k]  <= '0;
                hits_reg[k] <= '0;
            end
            else if (step)
            begin
                if (slot_t'(k) == idx)
                begin
                    deg_reg[k]  <= deg_reg[k] - deg_t'(out_cnt) + deg_t'(row[k]);
                    hits_reg[k] <= hits_reg[k] + out_cnt + hits_t'(row[k]);
                end
                else
                begin
                    deg_reg[k]  <= deg_reg[k] + deg_t'(row[k]);
                    hits_reg[k] <= hits_reg[k] + hits_t'(row[k]);
                end
            end
        end
    end

    assign deg  = deg_reg;
    assign hits = hits_reg;
endmodule

/* tb/goal_order_closure_agenda_tb.sv */
// Testbench: random and directed goal batches, closure/sort predictor, scoreboard checks.
module goal_order_closure_agenda_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import goca_pkg::*;

    typedef struct packed {
        logic [4:0]  entry_index;
        logic [15:0] fact;
        logic        last_in_entry;
        logic        last_overall;
    } agenda_beat_t;

    class agenda_board;
        row_t         rows_q[MAX_GOALS];
        fact_t        facts_q[MAX_GOALS];
        agenda_beat_t pending[$];
        int           mismatches;
        int           checked;
        int           batches;

        function new();
            mismatches = 0;
            checked = 0;
            batches = 0;
            foreach (rows_q[i])
            begin
                rows_q[i] = '0;
                facts_q[i] = '0;
            end
        endfunction

        function void note_goal(slot_t slot, logic [15:0] fact, logic [31:0] row, logic last);
            int n;
            row_t cl[MAX_GOALS];
            int deg[MAX_GOALS];
            int hits[MAX_GOALS];
            int order[MAX_GOALS];
            int pos;
            int entry;
            bit brk;
            agenda_beat_t b;
            row_t keep;
            rows_q[slot] = row;
            facts_q[slot] = fact;
            if (!last)
                return;
            batches++;
            n = int'(slot) + 1;
            keep = (n >= 32) ? '1 : row_t'((64'd1 << n) - 1);
            for (int i = 0; i < n; i++)
                cl[i] = rows_q[i] & keep;
            for (int j = 0; j < n; j++)
                for (int i = 0; i < n; i++)
                    if (cl[i][j])
                        cl[i] |= cl[j];
            for (int i = 0; i < n; i++)
            begin
                deg[i] = 0;
                hits[i] = 0;
            end
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    if (i != j && cl[i][j])
                    begin
                        deg[i]--;
                        deg[j]++;
                        hits[i]++;
                        hits[j]++;
                    end
            for (int i = 0; i < n; i++)
            begin
                if (hits[i] == 0)
                begin
                    order[i] = i;
                    continue;
                end
                pos = i;
                for (int p = 0; p < i; p++)
                    if (deg[i] < deg[order[p]] || hits[order[p]] == 0)
                    begin
                        pos = p;
                        break;
                    end
                for (int k = i; k > pos; k--)
                    order[k] = order[k-1];
                order[pos] = i;
            end
            entry = 0;
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                begin
                    brk = deg[order[i]] != deg[order[i-1]] ||
                          (hits[order[i]] == 0 && hits[order[i-1]] != 0);
                    if (brk)
                        entry++;
                end
                b.entry_index = entry[4:0];
                b.fact = facts_q[order[i]];
                b.last_overall = (i + 1 == n);
                b.last_in_entry = b.last_overall ||
                    deg[order[i+1]] != deg[order[i]] ||
                    (hits[order[i+1]] == 0 && hits[order[i]] != 0);
                pending.push_back(b);
            end
        endfunction

        function void check_beat(agenda_beat_t got);
            agenda_beat_t exp_b;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected agenda beat %p", got);
                return;
            end
            exp_b = pending.pop_front();
            if (got !== exp_b)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("agenda beat %0d: expected %p, got %p", checked, exp_b, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    goca_in_if  in_ch();
    goca_out_if out_ch();
    agenda_board board;
    int send_idle;
    int recv_stall;
    longint cycles;

    goal_order_closure_agenda dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && in_ch.valid && in_ch.ready)
            board.note_goal(in_ch.goal_slot, in_ch.goal_fact, in_ch.order_row,
                            in_ch.last_goal);
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_beat({out_ch.entry_index, out_ch.goal_fact_out,
                              out_ch.last_in_entry, out_ch.last_overall});
        if (cycles > 3000000)
        begin
            $display("timeout");
            $display("goal_order_closure_agenda: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall);

    task automatic send_goal(int slot, logic [15:0] fact, logic [31:0] row, bit last);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.goal_slot <= slot[4:0];
        in_ch.goal_fact <= fact;
        in_ch.order_row <= row;
        in_ch.last_goal <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_batch(int n, int style);
        logic [31:0] row;
        for (int s = 0; s < n; s++)
        begin
            case (style)
                0: row = $urandom();
                1: row = $urandom() & $urandom() & $urandom();
                2: row = (s + 1 < 32) ? (32'd1 << (s + 1)) : 32'd0;
                default: row = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
            endcase
            send_goal(s, 16'($urandom_range(65535)), row, s == n - 1);
        end
    endtask

    int items;
    int nb;

    initial
    begin
        board = new();
        send_idle = 0;
        recv_stall = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.goal_slot = '0;
        in_ch.goal_fact = '0;
        in_ch.order_row = '0;
        in_ch.last_goal = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_goal(0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_goal(0, 16'h0000, 32'h0000_0002, 1'b0);
        send_goal(1, 16'hA5A5, 32'h0000_0001, 1'b1);
        drain();
        send_goal(0, 16'h1111, 32'h0, 1'b0);
        send_goal(1, 16'h2222, 32'h0, 1'b0);
        send_goal(2, 16'h3333, 32'hFFFF_FFF8, 1'b1);
        drain();
        send_goal(1, 16'h4444, 32'h0000_0005, 1'b1);
        drain();
        send_batch(32, 0);
        drain();
        send_batch(32, 2);
        drain();
        send_goal(31, 16'h5A5A, 32'hFFFF_FFFF, 1'b1);
        drain();

        items = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 8 : 53) : 0;
            recv_stall = (ph == 2) ? 53 : ((ph == 3) ? 8 : 0);
            repeat (3)
            begin
                nb = ($urandom_range(9) == 0) ? 32 : $urandom_range(2, 8);
                send_batch(nb, $urandom_range(3));
                items += nb;
                drain();
            end
        end
        recv_stall = 0;
        repeat (200) @(negedge clk);

        $display("checked %0d agenda beats from %0d batches, %0d random goals",
                 board.checked, board.batches, items);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("goal_order_closure_agenda: match");
        else
            $display("goal_order_closure_agenda: mismatch");
        $finish;
    end
endmodule
